### sv/tgc_pkg.sv
// Shared types, codes and reset constants for the touch gesture classifier.
// No dependencies; every other file imports this package.
package tgc_pkg;

  // Default coordinate width; the top level exposes it as a parameter.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Fixed field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GEST_W     = 3;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP    = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_LONG   = 3'd3,
    GEST_LEFT   = 3'd4,
    GEST_RIGHT  = 3'd5,
    GEST_UP     = 3'd6,
    GEST_DOWN   = 3'd7
  } gesture_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOUBLE_TAP_WINDOW = 3'd0,
    CFG_LONG_PRESS        = 3'd1,
    CFG_TAP_MOVE_LIMIT    = 3'd2,
    CFG_SWIPE_TIME_LIMIT  = 3'd3,
    CFG_SWIPE_MIN_DIST_X  = 3'd4,
    CFG_SWIPE_MIN_DIST_Y  = 3'd5,
    CFG_TAP_TIME_LIMIT    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]  double_tap_window_ms;
    logic [WIN_W-1:0]  press_hold_ms;
    logic [DIST_W-1:0] tap_move_limit;
    logic [WIN_W-1:0]  swipe_time_limit_ms;
    logic [DIST_W-1:0] swipe_min_dist_x;
    logic [DIST_W-1:0] swipe_min_dist_y;
    logic [WIN_W-1:0]  tap_time_limit_ms;
  } tgc_cfg_t;

  localparam tgc_cfg_t CFG_RESET = '{
    double_tap_window_ms: 16'd300,
    press_hold_ms:        16'd600,
    tap_move_limit:       12'd20,
    swipe_time_limit_ms:  16'd500,
    swipe_min_dist_x:     12'd60,
    swipe_min_dist_y:     12'd60,
    tap_time_limit_ms:    16'd250
  };

endpackage

### sv/tgc_if.sv
// Valid/ready channel interfaces: touch samples, gesture results, register writes.
// Depends on tgc_pkg.
interface tgc_sample_if
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic                  pressed;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [TIME_W-1:0]     time_ms;

  modport source (output valid, mode, pressed, pos_x, pos_y, time_ms, input ready);
  modport sink   (input valid, mode, pressed, pos_x, pos_y, time_ms, output ready);
endinterface

interface tgc_result_if
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [GEST_W-1:0]     gesture;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;

  modport source (output valid, gesture, origin_x, origin_y, input ready);
  modport sink   (input valid, gesture, origin_x, origin_y, output ready);
endinterface

interface tgc_cfg_if
  import tgc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/touch_gesture_classifier_top.sv
// Top level of the touch gesture classifier: input register, decision core,
// result register and configuration registers. Depends on tgc_pkg, tgc_if,
// tgc_cfg_regs and tgc_core.
//
//   Channel   Dir  Payload                                   Handshake
//   sample_i  in   mode, pressed, pos_x, pos_y, time_ms      valid/ready
//   result_o  out  gesture, origin_x, origin_y               valid/ready
//   cfg_i     in   index (3 bit), data (16 bit)              valid/ready, ready always 1
//
// Flow: every sample gives exactly one result, registered first in the input
// register, then in the result register. One sample is accepted in every
// cycle while results are being taken; the touch state is updated by the
// combinational decision core as each sample leaves the input register, so
// consecutive samples chain without bubbles.
// Reset: rst_ni clears the touch state, both valid flags and loads the
// register defaults. Stalls: a held result blocks the core; sample_i.ready
// drops only when both the input and the result register are full and the
// result is not being taken.
module touch_gesture_classifier_top
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
)(
  input  logic         clk_i,
  input  logic         rst_ni,
  tgc_sample_if.sink   sample_i,
  tgc_result_if.source result_o,
  tgc_cfg_if.sink      cfg_i
);

  tgc_cfg_t cfg;

  // Input register.
  logic                  in_valid_q, in_valid_d;
  logic                  mode_q, pressed_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [TIME_W-1:0]     time_ms_q;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  gesture_e              gesture_q;
  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;

  gesture_e              core_gesture;
  logic [COORD_BITS-1:0] core_origin_x, core_origin_y;

  logic in_take, step;

  // Advance a sample into the core when the result slot is free or draining.
  assign step    = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_take = sample_i.valid && sample_i.ready;

  assign sample_i.ready = !in_valid_q || step;
  assign cfg_i.ready    = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold until the next handshake.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q    <= sample_i.mode;
      pressed_q <= sample_i.pressed;
      pos_x_q   <= sample_i.pos_x;
      pos_y_q   <= sample_i.pos_y;
      time_ms_q <= sample_i.time_ms;
    end
    if (step) begin
      gesture_q  <= core_gesture;
      origin_x_q <= core_origin_x;
      origin_y_q <= core_origin_y;
    end
  end

  tgc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  tgc_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cfg_i      (cfg),
    .mode_i     (mode_q),
    .pressed_i  (pressed_q),
    .pos_x_i    (pos_x_q),
    .pos_y_i    (pos_y_q),
    .time_ms_i  (time_ms_q),
    .gesture_o  (core_gesture),
    .origin_x_o (core_origin_x),
    .origin_y_o (core_origin_y)
  );

  assign result_o.valid    = out_valid_q;
  assign result_o.gesture  = gesture_q;
  assign result_o.origin_x = origin_x_q;
  assign result_o.origin_y = origin_y_q;

endmodule

### sv/tgc_cfg_regs.sv
// Configuration register file of the touch gesture classifier.
// Depends on tgc_pkg.
module tgc_cfg_regs
  import tgc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output tgc_cfg_t              cfg_o
);

  tgc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_DOUBLE_TAP_WINDOW: cfg_d.double_tap_window_ms = wr_data_i[WIN_W-1:0];
        CFG_LONG_PRESS:        cfg_d.press_hold_ms        = wr_data_i[WIN_W-1:0];
        CFG_TAP_MOVE_LIMIT:    cfg_d.tap_move_limit       = wr_data_i[DIST_W-1:0];
        CFG_SWIPE_TIME_LIMIT:  cfg_d.swipe_time_limit_ms  = wr_data_i[WIN_W-1:0];
        CFG_SWIPE_MIN_DIST_X:  cfg_d.swipe_min_dist_x     = wr_data_i[DIST_W-1:0];
        CFG_SWIPE_MIN_DIST_Y:  cfg_d.swipe_min_dist_y     = wr_data_i[DIST_W-1:0];
        CFG_TAP_TIME_LIMIT:    cfg_d.tap_time_limit_ms    = wr_data_i[WIN_W-1:0];
        default:               cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/tgc_core.sv
// Gesture decision logic and touch state registers; one sample per step.
// Depends on tgc_pkg.
module tgc_core
  import tgc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
)(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  tgc_cfg_t              cfg_i,
  input  logic                  mode_i,
  input  logic                  pressed_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [TIME_W-1:0]     time_ms_i,
  output gesture_e              gesture_o,
  output logic [COORD_BITS-1:0] origin_x_o,
  output logic [COORD_BITS-1:0] origin_y_o
);

  localparam int unsigned CMP_W = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;

  logic                  touching_q, touching_d;
  logic                  reported_q, reported_d;
  logic                  tap_waiting_q, tap_waiting_d;
  logic [COORD_BITS-1:0] begin_x_q, begin_x_d, begin_y_q, begin_y_d;
  logic [COORD_BITS-1:0] recent_x_q, recent_x_d, recent_y_q, recent_y_d;
  logic [TIME_W-1:0]     begin_time_q, begin_time_d, tap_time_q, tap_time_d;

  logic [TIME_W-1:0]     held, tap_gap;
  logic                  tap_expired, tap_in_window;
  logic [COORD_BITS-1:0] mdx, mdy, adx, ady;
  logic [CMP_W-1:0]      mdx_w, mdy_w, adx_w, ady_w, move_lim_w, min_x_w, min_y_w;
  logic                  still_now, still_rel, swipe_time_ok, tap_time_ok;
  gesture_e              gesture;

  // Elapsed times, wrapping modulo 2^32.
  assign held          = time_ms_i - begin_time_q;
  assign tap_gap       = time_ms_i - tap_time_q;
  assign tap_expired   = tap_gap > TIME_W'(cfg_i.double_tap_window_ms);
  assign tap_in_window = !tap_expired;
  assign swipe_time_ok = held <= TIME_W'(cfg_i.swipe_time_limit_ms);
  assign tap_time_ok   = held <= TIME_W'(cfg_i.tap_time_limit_ms);

  // Movement of the current sample and of the last pressed point.
  assign mdx = (pos_x_i > begin_x_q) ? pos_x_i - begin_x_q : begin_x_q - pos_x_i;
  assign mdy = (pos_y_i > begin_y_q) ? pos_y_i - begin_y_q : begin_y_q - pos_y_i;
  assign adx = (recent_x_q > begin_x_q) ? recent_x_q - begin_x_q : begin_x_q - recent_x_q;
  assign ady = (recent_y_q > begin_y_q) ? recent_y_q - begin_y_q : begin_y_q - recent_y_q;

  assign mdx_w      = CMP_W'(mdx);
  assign mdy_w      = CMP_W'(mdy);
  assign adx_w      = CMP_W'(adx);
  assign ady_w      = CMP_W'(ady);
  assign move_lim_w = CMP_W'(cfg_i.tap_move_limit);
  assign min_x_w    = CMP_W'(cfg_i.swipe_min_dist_x);
  assign min_y_w    = CMP_W'(cfg_i.swipe_min_dist_y);

  assign still_now = (mdx_w < move_lim_w) && (mdy_w < move_lim_w);
  assign still_rel = (adx_w < move_lim_w) && (ady_w < move_lim_w);

  always_comb begin
    touching_d    = touching_q;
    reported_d    = reported_q;
    tap_waiting_d = tap_waiting_q;
    begin_x_d     = begin_x_q;
    begin_y_d     = begin_y_q;
    recent_x_d    = recent_x_q;
    recent_y_d    = recent_y_q;
    begin_time_d  = begin_time_q;
    tap_time_d    = tap_time_q;
    gesture       = GEST_NONE;

    if (mode_i) begin
      touching_d    = 1'b0;
      reported_d    = 1'b0;
      tap_waiting_d = 1'b0;
    end else if (tap_waiting_q && !pressed_i && tap_expired) begin
      // Pending single tap times out; the step does nothing else.
      tap_waiting_d = 1'b0;
      gesture       = GEST_TAP;
    end else if (pressed_i && !touching_q) begin
      touching_d   = 1'b1;
      reported_d   = 1'b0;
      begin_x_d    = pos_x_i;
      begin_y_d    = pos_y_i;
      recent_x_d   = pos_x_i;
      recent_y_d   = pos_y_i;
      begin_time_d = time_ms_i;
    end else if (pressed_i) begin
      recent_x_d = pos_x_i;
      recent_y_d = pos_y_i;
      if (!reported_q && held >= TIME_W'(cfg_i.press_hold_ms) && still_now) begin
        reported_d    = 1'b1;
        tap_waiting_d = 1'b0;
        gesture       = GEST_LONG;
      end
    end else if (touching_q) begin
      // Release: classify from the last pressed point.
      touching_d = 1'b0;
      if (!reported_q) begin
        if (swipe_time_ok && adx_w >= min_x_w && adx_w > ady_w) begin
          tap_waiting_d = 1'b0;
          gesture       = (recent_x_q < begin_x_q) ? GEST_LEFT : GEST_RIGHT;
        end else if (swipe_time_ok && ady_w >= min_y_w && ady_w > adx_w) begin
          tap_waiting_d = 1'b0;
          gesture       = (recent_y_q < begin_y_q) ? GEST_UP : GEST_DOWN;
        end else if (tap_time_ok && still_rel) begin
          if (tap_waiting_q && tap_in_window) begin
            tap_waiting_d = 1'b0;
            gesture       = GEST_DOUBLE;
          end else begin
            tap_waiting_d = 1'b1;
            tap_time_d    = time_ms_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q    <= 1'b0;
      reported_q    <= 1'b0;
      tap_waiting_q <= 1'b0;
      begin_x_q     <= '0;
      begin_y_q     <= '0;
      recent_x_q    <= '0;
      recent_y_q    <= '0;
      begin_time_q  <= '0;
      tap_time_q    <= '0;
    end else if (step_i) begin
      touching_q    <= touching_d;
      reported_q    <= reported_d;
      tap_waiting_q <= tap_waiting_d;
      begin_x_q     <= begin_x_d;
      begin_y_q     <= begin_y_d;
      recent_x_q    <= recent_x_d;
      recent_y_q    <= recent_y_d;
      begin_time_q  <= begin_time_d;
      tap_time_q    <= tap_time_d;
    end
  end

  assign gesture_o  = gesture;
  assign origin_x_o = begin_x_d;
  assign origin_y_o = begin_y_d;

endmodule

### tb/touch_gesture_classifier_top_tb.sv
// Self-checking testbench for touch_gesture_classifier_top: drives touch samples and register
// writes over valid/ready channels and checks every gesture result against a local predictor.
// Depends on tgc_pkg, the tgc_if interfaces and the touch_gesture_classifier_top RTL.
module touch_gesture_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgc_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int CMAX = (1 << CB) - 1;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 4;
  localparam int TIMEOUT_CYCLES = 400000;
  // Idle time after all expected results are in, before the next step.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    gesture_e       gesture;
    logic [CB-1:0]  origin_x;
    logic [CB-1:0]  origin_y;
  } gesture_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tgc_sample_if #(.COORD_BITS(CB)) smp_if ();
  tgc_result_if #(.COORD_BITS(CB)) res_if ();
  tgc_cfg_if                       cfg_if ();

  touch_gesture_classifier_top #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: mirror of the touch tracker, the pending tap and the registers.
  // ---------------------------------------------------------------------------
  tgc_cfg_t       gcfg          = CFG_RESET;
  logic           finger_down   = 1'b0;
  logic           gesture_given = 1'b0;
  logic           tap_pending   = 1'b0;
  logic [CB-1:0]  start_x       = '0;
  logic [CB-1:0]  start_y       = '0;
  logic [CB-1:0]  last_x        = '0;
  logic [CB-1:0]  last_y        = '0;
  logic [31:0]    start_ms      = '0;
  logic [31:0]    tap_ms        = '0;

  gesture_result_t expected_q[$];

  // Bookkeeping.
  int   cycle_count  = 0;
  int   sent_count   = 0;
  int   result_count = 0;
  int   error_count  = 0;
  int   gesture_tally[8];
  int   idle_pct     = 0;   // chance per cycle that the sample side holds off
  int   stall_pct    = 0;   // chance per cycle that the result side is not ready
  logic [31:0] panel_ms;    // running timestamp for generated touches

  function automatic logic [CB-1:0] coord_dist(logic [CB-1:0] a, logic [CB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the touch tracker by one classify-mode sample and return its gesture.
  function automatic gesture_e classify_touch(logic pressed, logic [CB-1:0] x,
                                              logic [CB-1:0] y, logic [31:0] now);
    logic [31:0]   held;
    logic [CB-1:0] adx;
    logic [CB-1:0] ady;
    // A pending tap times out first on a released sample, before anything else.
    if (tap_pending && !pressed && (now - tap_ms) > gcfg.double_tap_window_ms) begin
      tap_pending = 1'b0;
      return GEST_TAP;
    end
    if (pressed && !finger_down) begin
      finger_down   = 1'b1;
      gesture_given = 1'b0;
      start_x       = x;
      start_y       = y;
      last_x        = x;
      last_y        = y;
      start_ms      = now;
      return GEST_NONE;
    end
    if (pressed) begin
      last_x = x;
      last_y = y;
      if (gesture_given) return GEST_NONE;
      if ((now - start_ms) >= gcfg.press_hold_ms &&
          coord_dist(x, start_x) < gcfg.tap_move_limit &&
          coord_dist(y, start_y) < gcfg.tap_move_limit) begin
        gesture_given = 1'b1;
        tap_pending   = 1'b0;
        return GEST_LONG;
      end
      return GEST_NONE;
    end
    if (finger_down) begin
      // Release: the last pressed position counts, not the release sample.
      finger_down = 1'b0;
      if (gesture_given) return GEST_NONE;
      held = now - start_ms;
      adx  = coord_dist(last_x, start_x);
      ady  = coord_dist(last_y, start_y);
      if (held <= gcfg.swipe_time_limit_ms) begin
        if (adx >= gcfg.swipe_min_dist_x && adx > ady) begin
          tap_pending = 1'b0;
          return (last_x < start_x) ? GEST_LEFT : GEST_RIGHT;
        end
        if (ady >= gcfg.swipe_min_dist_y && ady > adx) begin
          tap_pending = 1'b0;
          return (last_y < start_y) ? GEST_UP : GEST_DOWN;
        end
      end
      if (held <= gcfg.tap_time_limit_ms && adx < gcfg.tap_move_limit &&
          ady < gcfg.tap_move_limit) begin
        if (tap_pending && (now - tap_ms) <= gcfg.double_tap_window_ms) begin
          tap_pending = 1'b0;
          return GEST_DOUBLE;
        end
        tap_pending = 1'b1;
        tap_ms      = now;
      end
    end
    return GEST_NONE;
  endfunction

  function automatic gesture_result_t predict_result(logic mode, logic pressed,
                                                     logic [CB-1:0] x, logic [CB-1:0] y,
                                                     logic [31:0] now);
    gesture_result_t r;
    if (mode) begin
      // Clear: drop the touch and the pending tap, keep the begin point.
      finger_down   = 1'b0;
      gesture_given = 1'b0;
      tap_pending   = 1'b0;
      r.gesture     = GEST_NONE;
    end else begin
      r.gesture = classify_touch(pressed, x, y, now);
    end
    r.origin_x = start_x;
    r.origin_y = start_y;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict each accepted item, check results.
  // Everything is sampled at the rising edge, before this edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gesture_result_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_DOUBLE_TAP_WINDOW: gcfg.double_tap_window_ms = cfg_if.data;
          CFG_LONG_PRESS:        gcfg.press_hold_ms        = cfg_if.data;
          CFG_TAP_MOVE_LIMIT:    gcfg.tap_move_limit       = cfg_if.data[DIST_W-1:0];
          CFG_SWIPE_TIME_LIMIT:  gcfg.swipe_time_limit_ms  = cfg_if.data;
          CFG_SWIPE_MIN_DIST_X:  gcfg.swipe_min_dist_x     = cfg_if.data[DIST_W-1:0];
          CFG_SWIPE_MIN_DIST_Y:  gcfg.swipe_min_dist_y     = cfg_if.data[DIST_W-1:0];
          CFG_TAP_TIME_LIMIT:    gcfg.tap_time_limit_ms    = cfg_if.data;
          default: ;  // unmapped index: no register changes
        endcase
      end
      if (smp_if.valid && smp_if.ready) begin
        expected_q.push_back(predict_result(smp_if.mode, smp_if.pressed, smp_if.pos_x,
                                            smp_if.pos_y, smp_if.time_ms));
      end
      if (res_if.valid && res_if.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected (gesture %0d)",
                                  result_count, res_if.gesture));
        end else begin
          want = expected_q.pop_front();
          gesture_tally[want.gesture]++;
          if (res_if.gesture !== want.gesture)
            note_mismatch($sformatf("result %0d gesture: expected %s (%0d), got %0d",
                                    result_count, want.gesture.name(), want.gesture,
                                    res_if.gesture));
          if (res_if.origin_x !== want.origin_x)
            note_mismatch($sformatf("result %0d origin_x: expected %0d, got %0d",
                                    result_count, want.origin_x, res_if.origin_x));
          if (res_if.origin_y !== want.origin_y)
            note_mismatch($sformatf("result %0d origin_y: expected %0d, got %0d",
                                    result_count, want.origin_y, res_if.origin_y));
        end
      end
    end
  end

  // Result side: drop ready at random, one decision per cycle.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hang or a lost result ends up here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_q.size());
      $display("touch_gesture_classifier_top_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CB-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > CMAX) return CB'(CMAX);
    return CB'(v);
  endfunction

  function automatic int jitter(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // Pick a span around a limit; hit the limit and its neighbors often.
  function automatic int pick_span(int lim);
    case ($urandom_range(0, 7))
      0:       return lim;
      1:       return lim + 1;
      2:       return (lim > 0) ? lim - 1 : 0;
      default: return $urandom_range(0, lim + lim / 2 + 2);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one sample; coordinates are clamped to the panel. Valid stays high on
  // return so that a following item goes out back to back; wait_results() or
  // an idle gap lowers it.
  task automatic send_sample(logic mode, logic pressed, int x, int y, logic [31:0] now);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      smp_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    smp_if.valid   <= 1'b1;
    smp_if.mode    <= mode;
    smp_if.pressed <= pressed;
    smp_if.pos_x   <= clamp_coord(x);
    smp_if.pos_y   <= clamp_coord(y);
    smp_if.time_ms <= now;
    do @(posedge clk_i); while (!smp_if.ready);
    sent_count++;
  endtask

  // Hold off the sample side until every expected result is in, then settle.
  task automatic wait_results();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Write every register; the 12-bit ones get random junk in their upper bits,
  // which the block must ignore. Call only while the block is idle.
  task automatic apply_config(tgc_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_DOUBLE_TAP_WINDOW, c.double_tap_window_ms);
    write_reg(CFG_LONG_PRESS, c.press_hold_ms);
    write_reg(CFG_TAP_MOVE_LIMIT, {junk[CFG_DATA_W-1:DIST_W], c.tap_move_limit});
    write_reg(CFG_SWIPE_TIME_LIMIT, c.swipe_time_limit_ms);
    write_reg(CFG_SWIPE_MIN_DIST_X, {junk[CFG_DATA_W-1:DIST_W], c.swipe_min_dist_x});
    write_reg(CFG_SWIPE_MIN_DIST_Y, {junk[CFG_DATA_W-1:DIST_W], c.swipe_min_dist_y});
    write_reg(CFG_TAP_TIME_LIMIT, c.tap_time_limit_ms);
    write_reg(CFG_IDX_UNUSED, junk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic tgc_cfg_t rand_config();
    tgc_cfg_t c;
    c.double_tap_window_ms = WIN_W'($urandom_range(0, 800));
    c.press_hold_ms        = WIN_W'($urandom_range(0, 1500));
    c.tap_move_limit       = DIST_W'($urandom_range(0, 48));
    c.swipe_time_limit_ms  = WIN_W'($urandom_range(0, 900));
    c.swipe_min_dist_x     = DIST_W'($urandom_range(0, 400));
    c.swipe_min_dist_y     = DIST_W'($urandom_range(0, 400));
    c.tap_time_limit_ms    = WIN_W'($urandom_range(0, 500));
    return c;
  endfunction

  // One whole touch: press at the begin point, glide toward the end point in
  // nmoves pressed samples, release after dur ms at a random (ignored) spot.
  task automatic do_touch(int bx, int by, int ex, int ey, int jit, int dur, int nmoves);
    logic [31:0] t0;
    int          k;
    int          mx;
    int          my;
    t0 = panel_ms;
    send_sample(1'b0, 1'b1, bx, by, t0);
    for (k = 1; k <= nmoves; k++) begin
      mx = bx + (ex - bx) * k / nmoves;
      my = by + (ey - by) * k / nmoves;
      if (k < nmoves) begin
        mx += jitter(jit);
        my += jitter(jit);
      end
      send_sample(1'b0, 1'b1, mx, my, t0 + 32'(dur * k / (nmoves + 1)));
    end
    panel_ms = t0 + 32'(dur);
    send_sample(1'b0, 1'b0, $urandom_range(0, CMAX), $urandom_range(0, CMAX), panel_ms);
  endtask

  // Mostly well-formed gestures with random content, plus idle samples,
  // clears, broken touches and raw noise.
  task automatic run_gesture_mix(int n_items);
    int          target;
    int          bx;
    int          by;
    int          d;
    int          off;
    int          sx;
    int          sy;
    int          lim;
    logic [31:0] t;
    target   = sent_count + n_items;
    // Start near the 32-bit wrap half the time so time differences wrap.
    panel_ms = $urandom_range(0, 1) ? 32'hFFFF_F000 : $urandom;
    while (sent_count < target) begin
      bx  = $urandom_range(0, CMAX);
      by  = $urandom_range(0, CMAX);
      lim = int'(gcfg.tap_move_limit);
      sx  = $urandom_range(0, 1) ? 1 : -1;
      sy  = $urandom_range(0, 1) ? 1 : -1;
      panel_ms += 32'(pick_span(int'(gcfg.double_tap_window_ms)));
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          // Tap, often followed by a second one for a double tap.
          do_touch(bx, by, bx + jitter(lim), by + jitter(lim), lim / 2,
                   pick_span(int'(gcfg.tap_time_limit_ms)), $urandom_range(0, 2));
          if ($urandom_range(0, 1)) begin
            panel_ms += 32'(pick_span(int'(gcfg.double_tap_window_ms)));
            do_touch(bx, by, bx + jitter(lim), by + jitter(lim), lim / 2,
                     pick_span(int'(gcfg.tap_time_limit_ms)), $urandom_range(0, 2));
          end
        end
        4, 5: begin
          // Long press: hold nearly still past the threshold.
          do_touch(bx, by, bx + jitter(lim), by + jitter(lim), lim,
                   int'(gcfg.press_hold_ms) + pick_span(int'(gcfg.press_hold_ms) / 2),
                   $urandom_range(1, 4));
        end
        6, 7, 8, 9: begin
          // Swipe along one axis, with some off-axis drift up to a tie.
          if ($urandom_range(0, 1)) begin
            d   = pick_span(int'(gcfg.swipe_min_dist_x));
            off = $urandom_range(0, d);
            do_touch(bx, by, bx + sx * d, by + sy * off, 2,
                     pick_span(int'(gcfg.swipe_time_limit_ms)), $urandom_range(1, 3));
          end else begin
            d   = pick_span(int'(gcfg.swipe_min_dist_y));
            off = $urandom_range(0, d);
            do_touch(bx, by, bx + sx * off, by + sy * d, 2,
                     pick_span(int'(gcfg.swipe_time_limit_ms)), $urandom_range(1, 3));
          end
        end
        10: begin
          // Diagonal: equal travel on both axes is no swipe.
          d  = $urandom_range(0, 400);
          bx = $urandom_range(d, CMAX - d);
          by = $urandom_range(d, CMAX - d);
          do_touch(bx, by, bx + sx * d, by + sy * d, 0,
                   pick_span(int'(gcfg.swipe_time_limit_ms)), $urandom_range(1, 2));
        end
        11, 12: begin
          // Released samples around the window let a pending tap expire.
          repeat ($urandom_range(1, 3)) begin
            panel_ms += 32'(pick_span(int'(gcfg.double_tap_window_ms)));
            send_sample(1'b0, 1'b0, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                        panel_ms);
          end
        end
        13: begin
          send_sample(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, CMAX),
                      $urandom_range(0, CMAX), $urandom);
        end
        14: begin
          // Raw noise: any field, any time, the odd clear.
          repeat ($urandom_range(1, 4)) begin
            t = ($urandom_range(0, 3) == 0) ? $urandom : panel_ms + $urandom_range(0, 2000);
            panel_ms = t;
            send_sample($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)),
                        $urandom_range(0, CMAX), $urandom_range(0, CMAX), t);
          end
        end
        default: begin
          // Broken touch: press and move with no release; the next press
          // just moves it.
          send_sample(1'b0, 1'b1, bx, by, panel_ms);
          panel_ms += 32'($urandom_range(0, 800));
          send_sample(1'b0, 1'b1, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                      panel_ms);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked touches at reset settings: each gesture kind and the corner
  // cases of the tracker.
  task automatic test_directed_gestures();
    idle_pct  = 0;
    stall_pct = 0;
    // Clear on an idle block, then a release with no touch in progress.
    send_sample(1'b1, 1'b1, CMAX, CMAX, 32'hFFFF_FFFF);
    send_sample(1'b0, 1'b0, CMAX, 0, 32'd0);
    // Tap at the origin corner (release spot ignored), then a double tap.
    send_sample(1'b0, 1'b1, 0, 0, 32'd1000);
    send_sample(1'b0, 1'b0, CMAX, CMAX, 32'd1100);
    send_sample(1'b0, 1'b1, 5, 5, 32'd1200);
    send_sample(1'b0, 1'b0, 0, 0, 32'd1250);
    // Tap at the far corner, left to expire one ms past the window.
    send_sample(1'b0, 1'b1, CMAX, CMAX, 32'd2000);
    send_sample(1'b0, 1'b0, 0, 0, 32'd2100);
    send_sample(1'b0, 1'b0, 7, 7, 32'd2401);
    // Long press right at the hold and movement thresholds, then release.
    send_sample(1'b0, 1'b1, 2000, 2000, 32'd4000);
    send_sample(1'b0, 1'b1, 2019, 1981, 32'd4600);
    send_sample(1'b0, 1'b0, 0, 0, 32'd4700);
    // Left swipe at the minimum distance and the time limit.
    send_sample(1'b0, 1'b1, 1000, 1000, 32'd5000);
    send_sample(1'b0, 1'b1, 940, 1059, 32'd5200);
    send_sample(1'b0, 1'b0, 0, 0, 32'd5500);
    // Diagonal travel: neither axis dominates.
    send_sample(1'b0, 1'b1, 3000, 3000, 32'd6000);
    send_sample(1'b0, 1'b1, 3100, 2900, 32'd6100);
    send_sample(1'b0, 1'b0, 0, 0, 32'd6200);
    // Tap across the timestamp wrap, then a release that lands on the expiry
    // sample and is only handled by the next released sample.
    send_sample(1'b0, 1'b1, 10, 20, 32'hFFFF_FFF0);
    send_sample(1'b0, 1'b0, 0, 0, 32'h0000_0010);
    send_sample(1'b0, 1'b1, 300, 300, 32'h0000_0020);
    send_sample(1'b0, 1'b0, 0, 0, 32'h0000_0200);
    send_sample(1'b0, 1'b0, 0, 0, 32'h0000_0201);
    wait_results();
  endtask

  task automatic test_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    apply_config(rand_config());
    run_gesture_mix(420);
    wait_results();
  endtask

  task automatic test_sender_idle();
    idle_pct  = 58;
    stall_pct = 0;
    apply_config(rand_config());
    run_gesture_mix(420);
    wait_results();
  endtask

  // Reset values written back explicitly; pause mid-stream until drained.
  task automatic test_receiver_stall();
    idle_pct  = 0;
    stall_pct = 58;
    apply_config(CFG_RESET);
    run_gesture_mix(200);
    wait_results();
    run_gesture_mix(220);
    wait_results();
  endtask

  task automatic test_both_idle();
    idle_pct  = 31;
    stall_pct = 31;
    apply_config(rand_config());
    run_gesture_mix(420);
    wait_results();
  endtask

  // All registers at zero, then all at their maximum.
  task automatic test_config_extremes();
    idle_pct  = 20;
    stall_pct = 20;
    apply_config('0);
    run_gesture_mix(80);
    wait_results();
    apply_config('1);
    run_gesture_mix(80);
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before reset releases.
    smp_if.valid   <= 1'b0;
    smp_if.mode    <= 1'b0;
    smp_if.pressed <= 1'b0;
    smp_if.pos_x   <= '0;
    smp_if.pos_y   <= '0;
    smp_if.time_ms <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_gestures();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_config_extremes();
    wait_results();

    $display("Checked %0d results for %0d samples over directed touches, four pacing mixes",
             result_count, sent_count);
    $display({"and six register settings: tap %0d double %0d long %0d left %0d",
              " right %0d up %0d down %0d"},
             gesture_tally[GEST_TAP], gesture_tally[GEST_DOUBLE], gesture_tally[GEST_LONG],
             gesture_tally[GEST_LEFT], gesture_tally[GEST_RIGHT], gesture_tally[GEST_UP],
             gesture_tally[GEST_DOWN]);
    if (error_count == 0) begin
      $display("touch_gesture_classifier_top_tb passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("touch_gesture_classifier_top_tb failed");
    end
    $finish;
  end

endmodule
